### hdl/btcg_pkg.sv
// package for the bilevel template context generator
// transfer structs, line store word and size constants; no dependencies
package btcg_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int HELD_W    = COL_W + 1;
  localparam int SIZE_W    = 12;
  localparam int CTX_W     = 10;
  localparam logic [CTX_W-1:0] CTX_MASK = 10'h37a;

  typedef struct packed {
    logic              pixel;
    logic              symbol_start;
    logic [SIZE_W-1:0] symbol_width;
    logic [SIZE_W-1:0] symbol_height;
  } in_item_t;

  typedef struct packed {
    logic [CTX_W-1:0] next_context;
    logic             end_of_row;
    logic             end_of_symbol;
  } out_item_t;

  // one column of the line store: pixel two rows up and one row up
  typedef struct packed {
    logic two_above;
    logic above;
  } line_word_t;

endpackage

### hdl/bilevel_template_context_generator.sv
// top level of the bilevel template context generator
// depends on btcg_pkg for transfer structs, line store word and constants
//
// usage: one decoded pixel per input transfer, in raster order, with
// symbol_start and the symbol sizes given on pixel (0,0). each input transfer
// yields exactly one output transfer carrying the 10-bit context for the
// following pixel plus end-of-row and end-of-symbol flags.
// out_valid rises the cycle after the input transfer; throughput is one pixel
// per cycle while out_ready holds, set by the single read port of the line
// store, read three columns ahead and backed by a three-word window of x..x+2.
// the line store holds the two rows above per column and is rewritten in
// place as each pixel passes, so no row copy is needed at row end.
// the result sits in an output register; in_ready stays high while that
// register is empty or being taken, so a stalled receiver holds the block
// after one result and no transfer is lost.
// reset (rst_n low, synchronous) clears position, row count, context and
// sizes (1 x 1 symbol); the line store is not cleared, since its reads are
// gated by row and column.
module bilevel_template_context_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btcg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btcg_pkg::out_item_t out_data
);

  localparam int COL_W  = btcg_pkg::COL_W;
  localparam int HELD_W = btcg_pkg::HELD_W;
  localparam int SIZE_W = btcg_pkg::SIZE_W;
  localparam int CTX_W  = btcg_pkg::CTX_W;
  localparam int SUM_W  = HELD_W + 1;

  btcg_pkg::line_word_t line_mem [btcg_pkg::MAX_WIDTH];
  btcg_pkg::line_word_t rd_r;
  btcg_pkg::line_word_t win_r [3];
  btcg_pkg::line_word_t win_nxt [3];

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [CTX_W-1:0]  ctx_r, ctx_nxt;
  logic [HELD_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic [2:0]        cur_r, cur_nxt;
  logic [2:0]        prev_r, prev_nxt;
  logic              out_valid_r;
  btcg_pkg::out_item_t out_r;

  logic              accept;
  logic [HELD_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff, rows_eff, rows_inc;
  logic [CTX_W-1:0]  ctx_eff;
  logic [COL_W-1:0]  x;
  logic [SUM_W-1:0]  x_ext;
  logic              row_end, sym_end;
  logic [2:0]        cur_eff, prev_eff;
  logic              up3, up2;
  logic [COL_W-1:0]  raddr;
  btcg_pkg::line_word_t wdata;
  logic [CTX_W-1:0]  ctx_steady, ctx_row;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_data.symbol_start) begin
      if (in_data.symbol_width == '0) begin
        w_eff = HELD_W'(1);
      end else if (32'(in_data.symbol_width) > btcg_pkg::MAX_WIDTH) begin
        w_eff = HELD_W'(btcg_pkg::MAX_WIDTH);
      end else begin
        w_eff = HELD_W'(in_data.symbol_width);
      end
      h_eff    = (in_data.symbol_height == '0) ? SIZE_W'(1) : in_data.symbol_height;
      x        = '0;
      rows_eff = '0;
      ctx_eff  = '0;
    end else begin
      w_eff    = width_r;
      h_eff    = height_r;
      x        = col_r;
      rows_eff = rows_r;
      ctx_eff  = ctx_r;
    end

    x_ext    = SUM_W'(x);
    row_end  = !((x_ext + SUM_W'(1)) < SUM_W'(w_eff));
    rows_inc = rows_eff + SIZE_W'(1);
    sym_end  = row_end && !(rows_inc < h_eff);

    // first three columns of this row and the row above, for row start
    for (int c = 0; c < 3; c++) begin
      cur_eff[c]  = (x == COL_W'(c)) ? in_data.pixel : cur_r[c];
      prev_eff[c] = (x == COL_W'(c)) ? win_r[0].above : prev_r[c];
    end

    up3 = (rows_eff != '0) && ((x_ext + SUM_W'(3)) < SUM_W'(w_eff)) && rd_r.above;
    up2 = (rows_eff > SIZE_W'(1)) && ((x_ext + SUM_W'(2)) < SUM_W'(w_eff))
          && win_r[2].two_above;
    ctx_steady = ((ctx_eff << 1) & btcg_pkg::CTX_MASK) | (CTX_W'(up3) << 2)
               | (CTX_W'(up2) << 7) | CTX_W'(in_data.pixel);

    ctx_row = '0;
    ctx_row[8] = (rows_eff != '0) && prev_eff[0];
    ctx_row[7] = (rows_eff != '0) && (w_eff > HELD_W'(1)) && prev_eff[1];
    ctx_row[4] = cur_eff[0];
    ctx_row[3] = (w_eff > HELD_W'(1)) && cur_eff[1];
    ctx_row[2] = (w_eff > HELD_W'(2)) && cur_eff[2];

    wdata.two_above = win_r[0].above;
    wdata.above     = in_data.pixel;

    col_nxt    = col_r;
    rows_nxt   = rows_r;
    ctx_nxt    = ctx_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    for (int c = 0; c < 3; c++) begin
      win_nxt[c] = win_r[c];
    end

    if (accept) begin
      width_nxt  = w_eff;
      height_nxt = h_eff;
      cur_nxt    = cur_eff;
      prev_nxt   = prev_eff;
      if (!row_end) begin
        col_nxt    = x + COL_W'(1);
        rows_nxt   = rows_eff;
        ctx_nxt    = ctx_steady;
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = rd_r;
      end else begin
        col_nxt = '0;
        // window reloads columns 0..2 of the rows just shifted down
        for (int c = 0; c < 3; c++) begin
          win_nxt[c].two_above = prev_eff[c];
          win_nxt[c].above     = cur_eff[c];
        end
        if (sym_end) begin
          rows_nxt = '0;
          ctx_nxt  = '0;
        end else begin
          rows_nxt = rows_inc;
          ctx_nxt  = ctx_row;
        end
      end
    end

    raddr = col_nxt + COL_W'(3);
  end

  // line store: one write, one registered read with write forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[x] <= wdata;
    end
    if (accept && (x == raddr)) begin
      rd_r <= wdata;
    end else begin
      rd_r <= line_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      win_r[c] <= win_nxt[c];
    end
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    if (accept) begin
      out_r.next_context  <= row_end ? (sym_end ? '0 : ctx_row) : ctx_steady;
      out_r.end_of_row    <= row_end;
      out_r.end_of_symbol <= sym_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_r      <= '0;
      ctx_r       <= '0;
      width_r     <= HELD_W'(1);
      height_r    <= SIZE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      rows_r   <= rows_nxt;
      ctx_r    <= ctx_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
